### rtl/core/a85_pkg.sv
// Shared types, constants and slot codes of the ASCII85 stream encoder.
package a85_pkg;

	localparam logic [7:0] CHAR_BANG  = 8'h21;
	localparam logic [7:0] CHAR_Z     = 8'h7A;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_TILDE = 8'h7E;
	localparam logic [7:0] CHAR_GT    = 8'h3E;

	localparam logic [7:0] LINE_LIMIT_RESET = 8'd80;
	localparam logic [8:0] TRAILER_WRAP_COL = 9'd253;

	// floor(n / 85) == (n * RECIP_85) >> RECIP_SHIFT for every 32-bit n.
	localparam logic [31:0] RECIP_85    = 32'd3233857729;
	localparam int          RECIP_SHIFT = 38;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Output slots, emitted from lowest to highest.
	localparam int NUM_SLOTS   = 11;
	localparam int SLOT_PRE_NL = 0;
	localparam int SLOT_Z      = 1;
	localparam int SLOT_DIG0   = 2;
	localparam int SLOT_TRL_NL = 7;
	localparam int SLOT_TILDE  = 8;
	localparam int SLOT_GT     = 9;
	localparam int SLOT_END_NL = 10;

	localparam logic OP_DATA   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// One classified command from the front to the back.
	typedef struct packed {
		logic [31:0] val;
		logic        nl_pre;
		logic        zchar;
		logic [2:0]  ndig;
		logic        fin;
		logic        nl_trl;
	} cmd_t;

	// A converted command, ready to be emitted.
	typedef struct packed {
		logic            nl_pre;
		logic            zchar;
		logic [2:0]      ndig;
		logic            fin;
		logic            nl_trl;
		logic [4:0][7:0] digs;
	} job_t;

endpackage

### rtl/core/ascii85_stream_encoder_unit.sv
// Top level of the ASCII85 stream encoder with line wrapping.
//
// Input channel: in_valid/in_stall with operation and data_byte. A data byte
// is gathered into a 32-bit tuple; a finish item flushes the partial tuple
// and writes the "~>" trailer and a newline, then clears the tuple and column.
// Output channel: out_valid/out_stall, one out_char per transfer; last marks
// the final character caused by one input item.
// cfg_wr_en/cfg_wr_data write line_limit (reset 80); write only while idle.
// The digit converter works out a tuple's digits one at a time through the
// reciprocal multiplier and takes no new tuple until its job is taken.
// A two-entry command queue separates the byte front from the converter, and
// the converter works on the next tuple while the emitter sends the last one.
// Reset clears all control state, empties the queue and sets line_limit to 80.
// When the receiver stalls, the output holds its character; the emitter,
// converter and queue fill in turn, and in_stall rises once the queue is full.
module ascii85_stream_encoder_unit import a85_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	logic q_full;
	logic push;
	cmd_t wr_cmd;
	logic q_pop;
	logic q_valid;
	cmd_t rd_cmd;
	logic job_valid;
	job_t job;
	logic job_take;

	a85_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.data_byte  (data_byte),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.q_full     (q_full),
		.push       (push),
		.cmd        (wr_cmd)
	);

	a85_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_cmd  (wr_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.rd_valid(q_valid),
		.rd_cmd  (rd_cmd)
	);

	a85_conv u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (rd_cmd),
		.q_pop    (q_pop),
		.job_valid(job_valid),
		.job      (job),
		.job_take (job_take)
	);

	a85_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (job),
		.job_take (job_take),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char (out_char),
		.last     (last)
	);

endmodule

### rtl/core/a85_front.sv
// Front part: accepts bytes, gathers tuples and decides line wraps.
module a85_front import a85_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [7:0] data_byte,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       q_full,
	output logic       push,
	output cmd_t       cmd
);

	logic [7:0]  line_limit_q;
	logic [23:0] pend_q;
	logic [1:0]  cnt_q;
	logic [7:0]  col_q;

	logic        accept;
	logic [9:0]  lim10;
	logic [9:0]  col10;
	logic [9:0]  thr;
	logic        wrap;
	logic        zero_tuple;
	logic [31:0] full_val;
	logic [31:0] pad_val;
	logic [7:0]  col_base;
	logic [8:0]  col_fin;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign lim10      = {2'b00, line_limit_q};
	assign col10      = {2'b00, col_q};
	assign full_val   = {pend_q, data_byte};
	assign zero_tuple = (full_val == 32'd0);

	always_comb begin
		if (operation == OP_FINISH) begin
			thr = lim10 - 10'd1 - {8'd0, cnt_q};
		end else if (zero_tuple) begin
			thr = lim10 - 10'd1;
		end else begin
			thr = lim10 - 10'd5;
		end
	end

	// Thresholds are signed; a negative one wraps before every tuple.
	assign wrap     = $signed(col10) >= $signed(thr);
	assign col_base = wrap ? 8'd0 : col_q;

	always_comb begin
		case (cnt_q)
			2'd1:    pad_val = {pend_q[7:0], 24'd0};
			2'd2:    pad_val = {pend_q[15:0], 16'd0};
			default: pad_val = {pend_q, 8'd0};
		endcase
	end

	always_comb begin
		if (cnt_q == 2'd0) begin
			col_fin = {1'b0, col_q};
		end else begin
			col_fin = {1'b0, col_base} + {7'd0, cnt_q} + 9'd1;
		end
	end

	always_comb begin
		cmd = '0;
		if (operation == OP_FINISH) begin
			push       = accept;
			cmd.val    = pad_val;
			cmd.nl_pre = (cnt_q != 2'd0) && wrap;
			cmd.ndig   = (cnt_q == 2'd0) ? 3'd0 : ({1'b0, cnt_q} + 3'd1);
			cmd.fin    = 1'b1;
			cmd.nl_trl = col_fin >= TRAILER_WRAP_COL;
		end else begin
			push       = accept && (cnt_q == 2'd3);
			cmd.val    = full_val;
			cmd.nl_pre = wrap;
			cmd.zchar  = zero_tuple;
			cmd.ndig   = zero_tuple ? 3'd0 : 3'd5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= LINE_LIMIT_RESET;
			pend_q       <= '0;
			cnt_q        <= '0;
			col_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				line_limit_q <= cfg_wr_data;
			end
			if (accept) begin
				if (operation == OP_FINISH) begin
					pend_q <= '0;
					cnt_q  <= '0;
					col_q  <= '0;
				end else if (cnt_q != 2'd3) begin
					pend_q <= {pend_q[15:0], data_byte};
					cnt_q  <= cnt_q + 2'd1;
				end else begin
					pend_q <= '0;
					cnt_q  <= '0;
					col_q  <= col_base + (zero_tuple ? 8'd1 : 8'd5);
				end
			end
		end
	end

endmodule

### rtl/core/a85_queue.sv
// Short command queue between the front and the back.
module a85_queue import a85_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output logic rd_valid,
	output cmd_t rd_cmd
);

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == Q_CNT_W'(Q_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/a85_conv.sv
// Back part, first half: iterative base-85 digit conversion of one tuple.
module a85_conv import a85_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cmd_t q_cmd,
	output logic q_pop,
	output logic job_valid,
	output job_t job,
	input  logic job_take
);

	logic            busy_q;
	logic            conv_q;
	logic            phase_q;
	logic [1:0]      step_q;
	logic [31:0]     n_q;
	logic [63:0]     prod_q;
	cmd_t            cmd_q;
	logic [4:0][7:0] digs_q;

	logic        done;
	logic        load;
	logic [31:0] quot;
	logic [31:0] quot85;
	logic [31:0] rem;
	logic [2:0]  didx;

	assign done      = busy_q && !conv_q;
	assign load      = q_valid && (!busy_q || (done && job_take));
	assign q_pop     = load;
	assign job_valid = done;

	assign job.nl_pre = cmd_q.nl_pre;
	assign job.zchar  = cmd_q.zchar;
	assign job.ndig   = cmd_q.ndig;
	assign job.fin    = cmd_q.fin;
	assign job.nl_trl = cmd_q.nl_trl;
	assign job.digs   = digs_q;

	assign quot   = {6'd0, prod_q[63:RECIP_SHIFT]};
	assign quot85 = (quot << 6) + (quot << 4) + (quot << 2) + quot;
	assign rem    = n_q - quot85;
	assign didx   = 3'd4 - {1'b0, step_q};

	// Each step has a multiply phase and then a remainder phase.
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= q_cmd;
			n_q   <= q_cmd.val;
		end else if (conv_q) begin
			if (!phase_q) begin
				prod_q <= 64'(n_q) * 64'(RECIP_85);
			end else begin
				digs_q[didx] <= {1'b0, rem[6:0]} + CHAR_BANG;
				n_q          <= quot;
				if (step_q == 2'd3) begin
					digs_q[0] <= quot[7:0] + CHAR_BANG;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			conv_q  <= 1'b0;
			phase_q <= 1'b0;
			step_q  <= '0;
		end else begin
			if (load) begin
				busy_q  <= 1'b1;
				conv_q  <= (q_cmd.ndig != 3'd0);
				phase_q <= 1'b0;
				step_q  <= '0;
			end else if (done && job_take) begin
				busy_q <= 1'b0;
			end else if (conv_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						conv_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

### rtl/core/a85_emit.sv
// Back part, second half: sends the characters of one job, one per cycle while out_stall is low.
module a85_emit import a85_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  job_t       job,
	output logic       job_take,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last
);

	logic [NUM_SLOTS-1:0] mask_q;
	logic [4:0][7:0]      digs_q;

	logic [NUM_SLOTS-1:0] low;
	logic [NUM_SLOTS-1:0] new_mask;
	logic [7:0]           slot_chars [NUM_SLOTS];
	logic                 single;
	logic                 xfer;

	assign low       = mask_q & (~mask_q + 1'b1);
	assign single    = (mask_q != '0) && ((mask_q & (mask_q - 1'b1)) == '0);
	assign out_valid = (mask_q != '0);
	assign last      = single;
	assign xfer      = out_valid && !out_stall;
	assign job_take  = (mask_q == '0) || (single && xfer);

	always_comb begin
		new_mask              = '0;
		new_mask[SLOT_PRE_NL] = job.nl_pre;
		new_mask[SLOT_Z]      = job.zchar;
		for (int k = 0; k < 5; k++) begin
			new_mask[SLOT_DIG0 + k] = (3'(k) < job.ndig);
		end
		new_mask[SLOT_TRL_NL] = job.fin && job.nl_trl;
		new_mask[SLOT_TILDE]  = job.fin;
		new_mask[SLOT_GT]     = job.fin;
		new_mask[SLOT_END_NL] = job.fin;
	end

	always_comb begin
		slot_chars[SLOT_PRE_NL] = CHAR_NL;
		slot_chars[SLOT_Z]      = CHAR_Z;
		for (int k = 0; k < 5; k++) begin
			slot_chars[SLOT_DIG0 + k] = digs_q[k];
		end
		slot_chars[SLOT_TRL_NL] = CHAR_NL;
		slot_chars[SLOT_TILDE]  = CHAR_TILDE;
		slot_chars[SLOT_GT]     = CHAR_GT;
		slot_chars[SLOT_END_NL] = CHAR_NL;
	end

	always_comb begin
		out_char = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (low[i]) begin
				out_char = out_char | slot_chars[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take && job_valid) begin
			digs_q <= job.digs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (job_take) begin
			mask_q <= job_valid ? new_mask : '0;
		end else if (xfer) begin
			mask_q <= mask_q & ~low;
		end
	end

endmodule

### tb/ascii85_stream_encoder_unit_test.sv
// Self-checking testbench for the ASCII85 stream encoder with line wrapping.
module ascii85_stream_encoder_unit_test;
	import a85_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} enc_char_t;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BLOCKS} rx_mode_t;

	localparam logic [7:0] LIMIT_MIN = 8'd6;
	localparam logic [7:0] LIMIT_MAX = 8'd255;
	localparam int SETTLE_CYCLES = 30;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       operation = OP_DATA;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       last;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;

	// Predicted encoder state.
	logic [7:0]  line_limit_cfg = LINE_LIMIT_RESET;
	logic [23:0] tuple_bytes = '0;
	int          tuple_fill = 0;
	int          line_col = 0;

	enc_char_t   expected_chars[$];
	logic [7:0]  new_chars[$];
	int          fail_count = 0;
	int          burst_left = 0;
	bit          steady = 1'b0;
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_tick = 0;

	ascii85_stream_encoder_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last        (last),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #1 clk = ~clk;

	// Most significant digit lands in element 0.
	function automatic logic [4:0][7:0] base85_digits(input logic [31:0] v);
		logic [4:0][7:0] d;
		for (int k = 4; k > 0; k--) begin
			d[k] = 8'(v % 85) + CHAR_BANG;
			v = v / 85;
		end
		d[0] = 8'(v) + CHAR_BANG;
		return d;
	endfunction

	// Thresholds are signed, so a tiny line limit forces a break before every tuple.
	task automatic break_line_if(input int threshold);
		if (line_col >= threshold) begin
			new_chars.push_back(CHAR_NL);
			line_col = 0;
		end
	endtask

	task automatic predict_chars(input logic op, input logic [7:0] b);
		logic [31:0]     tuple;
		logic [4:0][7:0] digs;
		int              fill;
		new_chars.delete();
		if (op == OP_DATA) begin
			if (tuple_fill < 3) begin
				tuple_bytes = {tuple_bytes[15:0], b};
				tuple_fill++;
			end else begin
				tuple = {tuple_bytes, b};
				tuple_bytes = '0;
				tuple_fill = 0;
				if (tuple == 32'd0) begin
					break_line_if(int'(line_limit_cfg) - 1);
					new_chars.push_back(CHAR_Z);
					line_col = (line_col + 1) % 256;
				end else begin
					break_line_if(int'(line_limit_cfg) - 5);
					digs = base85_digits(tuple);
					for (int k = 0; k < 5; k++)
						new_chars.push_back(digs[k]);
					line_col = (line_col + 5) % 256;
				end
			end
		end else begin
			fill = tuple_fill;
			if (fill != 0) begin
				tuple = {tuple_bytes, 8'h00} << (8 * (3 - fill));
				break_line_if(int'(line_limit_cfg) - 1 - fill);
				digs = base85_digits(tuple);
				for (int k = 0; k <= fill; k++)
					new_chars.push_back(digs[k]);
				line_col = line_col + fill + 1;
			end
			if (line_col >= int'(TRAILER_WRAP_COL))
				new_chars.push_back(CHAR_NL);
			new_chars.push_back(CHAR_TILDE);
			new_chars.push_back(CHAR_GT);
			new_chars.push_back(CHAR_NL);
			tuple_bytes = '0;
			tuple_fill = 0;
			line_col = 0;
		end
		foreach (new_chars[i])
			expected_chars.push_back('{ch: new_chars[i], fin: (i == new_chars.size() - 1)});
	endtask

	task automatic send_item(input logic op, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(0, 7);
			if ($urandom_range(0, 2) == 0)
				gap = 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		predict_chars(op, b);
	endtask

	task automatic send_tuple(input logic [31:0] v);
		for (int k = 3; k >= 0; k--)
			send_item(OP_DATA, v[8*k +: 8]);
	endtask

	// The data byte is ignored on finish, so it carries random bits.
	task automatic send_finish();
		send_item(OP_FINISH, 8'($urandom));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_line_limit(input logic [7:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		line_limit_cfg = v;
	endtask

	// Receiver: picks a random stall pattern, or none while the phase is steady.
	always @(posedge clk) begin
		rx_tick++;
		if (rx_tick % 64 == 0)
			rx_mode = steady ? RX_OPEN : rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:     out_stall <= 1'b0;
			RX_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
			RX_PERIODIC: out_stall <= (rx_tick % 5 < 2);
			default:     out_stall <= (rx_tick % 32 >= 24);
		endcase
	end

	always @(posedge clk) begin : check_output
		enc_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				$error("out_char: no character expected, got %h (last %b)", out_char, last);
				fail_count++;
			end else begin
				want = expected_chars.pop_front();
				if (out_char !== want.ch) begin
					$error("out_char: expected %h, actual %h", want.ch, out_char);
					fail_count++;
				end
				if (last !== want.fin) begin
					$error("last: expected %b, actual %b", want.fin, last);
					fail_count++;
				end
			end
		end
	end

	task automatic test_tuple_encoding();
		send_tuple(32'h0000_0000);
		send_tuple(32'hFFFF_FFFF);
		send_tuple(32'h0000_0001);
		send_tuple(32'h8000_0000);
		send_finish();
		send_finish();
		send_item(OP_DATA, 8'hFF);
		send_finish();
		send_item(OP_DATA, 8'h00);
		send_item(OP_DATA, 8'h00);
		send_finish();
		send_item(OP_DATA, 8'hA5);
		send_item(OP_DATA, 8'h5A);
		send_item(OP_DATA, 8'hFF);
		send_finish();
	endtask

	task automatic test_line_wrap();
		logic [7:0] limits[3];
		limits = '{LIMIT_MIN, 8'd1, 8'd0};
		foreach (limits[i]) begin
			write_line_limit(limits[i]);
			for (int t = 0; t < 2; t++) begin
				send_tuple($urandom);
				send_tuple(32'h0);
			end
			send_tuple(32'h0);
			send_item(OP_DATA, 8'($urandom));
			send_item(OP_DATA, 8'($urandom));
			send_finish();
		end
	endtask

	// Fill a 255-wide line to the trailer break point, then finish with leftovers.
	task automatic test_trailer_wrap();
		write_line_limit(LIMIT_MAX);
		for (int t = 0; t < 50; t++)
			send_tuple({8'($urandom_range(1, 255)), 24'($urandom)});
		repeat (3) send_item(OP_DATA, 8'($urandom));
		send_finish();
	endtask

	task automatic test_random_stream(input int n_items);
		logic [7:0] limits[4];
		int         sent;
		int         kind;
		int         len;
		logic [7:0] b;
		limits = '{8'($urandom_range(6, 255)), LIMIT_MAX, LIMIT_MIN, LINE_LIMIT_RESET};
		foreach (limits[p]) begin
			write_line_limit(limits[p]);
			steady = (p == 3);
			sent = 0;
			while (sent < n_items / 4) begin
				kind = $urandom_range(0, 9);
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 4;
				for (int k = 0; k < len; k++) begin
					if (kind < 2)
						b = 8'h00;
					else if (kind < 3)
						b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					else
						b = 8'($urandom);
					send_item(OP_DATA, b);
				end
				sent += len;
				if (len < 4 || $urandom_range(0, 11) == 0) begin
					send_finish();
					sent++;
				end
			end
			send_finish();
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_tuple_encoding();
		test_line_wrap();
		test_trailer_wrap();
		test_random_stream(40);
		wait_idle();
		if (fail_count == 0)
			$display("PASS ascii85_stream_encoder_unit");
		else
			$display("FAIL ascii85_stream_encoder_unit");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("FAIL ascii85_stream_encoder_unit");
		$finish;
	end

endmodule

### files.f
rtl/core/a85_pkg.sv
rtl/core/a85_front.sv
rtl/core/a85_queue.sv
rtl/core/a85_conv.sv
rtl/core/a85_emit.sv
rtl/core/ascii85_stream_encoder_unit.sv
tb/ascii85_stream_encoder_unit_test.sv
